/* rtl/core/ptc_pkg.sv */
// shared types, constants and arithmetic helpers of the compensation block
package ptc_pkg;

  localparam logic [7:0]  ChipId      = 8'h58;
  localparam logic [31:0] POffset     = 32'd64000;
  localparam logic [31:0] PRawFull    = 32'd1048576;
  localparam logic [31:0] PScale      = 32'd3125;
  localparam logic [31:0] PHalfRange  = 32'h8000_0000;
  localparam logic [31:0] POne        = 32'd32768;
  localparam logic [31:0] TRound      = 32'd128;
  localparam int          QueueDepth  = 4;
  localparam int          CfgIdxW     = 3;
  localparam int          DivBits     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegT1, RegT2, RegT3, RegP1, RegP23, RegP45, RegP67, RegP89
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [31:0] p23;
    logic [31:0] p45;
    logic [31:0] p67;
    logic [31:0] p89;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic [19:0] adc_t;
    logic [19:0] adc_p;
  } meas_t;

  typedef struct packed {
    logic        ok;
    logic        zero;
    logic        dbl;
    logic [19:0] adc_p;
    logic [19:0] adc_t;
    logic [31:0] temp;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } stage_t;

  typedef struct packed {
    logic        ok;
    logic        zero;
    logic        dbl;
    logic [31:0] temp;
  } dside_t;

  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

/* rtl/core/ptc_front.sv */
// front end: unpacks the burst bytes and checks the identity byte
module ptc_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          chip_id_i,
  input  logic [7:0]          press_msb_i,
  input  logic [7:0]          press_lsb_i,
  input  logic [7:0]          press_xlsb_i,
  input  logic [7:0]          temp_msb_i,
  input  logic [7:0]          temp_lsb_i,
  input  logic [7:0]          temp_xlsb_i,
  input  logic                full_i,
  output logic                push_o,
  output ptc_pkg::meas_t      meas_o
);

  assign in_stall_o   = full_i;
  assign push_o       = in_valid_i && !full_i;
  assign meas_o.ok    = (chip_id_i == ptc_pkg::ChipId);
  assign meas_o.adc_t = {temp_msb_i, temp_lsb_i, temp_xlsb_i[7:4]};
  assign meas_o.adc_p = {press_msb_i, press_lsb_i, press_xlsb_i[7:4]};

endmodule

/* rtl/core/ptc_fifo.sv */
// short queue between front end and datapath
module ptc_fifo #(
  parameter int Depth = ptc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptc_pkg::meas_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ptc_pkg::meas_t data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ptc_pkg::meas_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
`endif

endmodule

/* rtl/core/ptc_div.sv */
// pipelined unsigned 32-bit divider, one quotient bit per stage
module ptc_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     dividend_i,
  input  logic [31:0]     divisor_i,
  input  ptc_pkg::dside_t side_i,
  output logic            valid_o,
  output logic [31:0]     quotient_o,
  output ptc_pkg::dside_t side_o
);

  localparam int N = ptc_pkg::DivBits;

  logic            vld_q  [N];
  logic [31:0]     rem_q  [N];
  logic [31:0]     dq_q   [N];
  logic [31:0]     den_q  [N];
  ptc_pkg::dside_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic            v_in;
    logic [31:0]     rem_in, dq_in, den_in;
    ptc_pkg::dside_t s_in;
    logic [32:0]     sh, diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign den_in = divisor_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign den_in = den_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign sh   = {rem_in, dq_in[31]};
    assign diff = sh - {1'b0, den_in};
    assign ge   = (sh >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[31:0] : sh[31:0];
        dq_q[k]   <= {dq_in[30:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o    = vld_q[N-1];
  assign quotient_o = dq_q[N-1];
  assign side_o     = side_q[N-1];

endmodule

/* rtl/core/ptc_back.sv */
// datapath: temperature and pressure compensation pipeline
module ptc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ptc_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  input  ptc_pkg::meas_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    temperature_centi_o,
  output logic [31:0]    pressure_pa_o,
  output logic           device_ok_o
);

  localparam int NPre  = 9;
  localparam int NPost = 3;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic        en;

  ptc_pkg::stage_t st0;
  ptc_pkg::stage_t st_q [1:NPre];
  ptc_pkg::stage_t st_d [1:NPre];
  logic            sv_q [1:NPre];
  ptc_pkg::stage_t pt_q [NPost];
  ptc_pkg::stage_t pt_d [NPost];
  logic            pv_q [NPost];

  logic            div_in_v, div_out_v;
  logic [31:0]     div_dvd, div_q;
  ptc_pkg::dside_t div_side_in, div_side_out;

  assign t1 = {16'd0, cfg_i.t1};
  assign t2 = ptc_pkg::sx16(cfg_i.t2);
  assign t3 = ptc_pkg::sx16(cfg_i.t3);
  assign p1 = {16'd0, cfg_i.p1};
  assign p2 = ptc_pkg::sx16(cfg_i.p23[15:0]);
  assign p3 = ptc_pkg::sx16(cfg_i.p23[31:16]);
  assign p4 = ptc_pkg::sx16(cfg_i.p45[15:0]);
  assign p5 = ptc_pkg::sx16(cfg_i.p45[31:16]);
  assign p6 = ptc_pkg::sx16(cfg_i.p67[15:0]);
  assign p7 = ptc_pkg::sx16(cfg_i.p67[31:16]);
  assign p8 = ptc_pkg::sx16(cfg_i.p89[15:0]);
  assign p9 = ptc_pkg::sx16(cfg_i.p89[31:16]);

  assign en      = !(pv_q[NPost-1] && out_stall_i);
  assign q_pop_o = en && !q_empty_i;

  always_comb begin
    st0       = '0;
    st0.ok    = q_data_i.ok;
    st0.adc_t = q_data_i.adc_t;
    st0.adc_p = q_data_i.adc_p;
  end

  always_comb begin
    logic [31:0] adct, pres;
    adct = {12'd0, st0.adc_t};
    // temperature
    st_d[1]   = st0;
    st_d[1].x = ptc_pkg::mul_lo((adct >> 3) - (t1 << 1), t2);
    st_d[1].y = ptc_pkg::mul_lo((adct >> 4) - t1, (adct >> 4) - t1);
    st_d[2]   = st_q[1];
    st_d[2].x = ptc_pkg::asr(st_q[1].x, 11);
    st_d[2].y = ptc_pkg::mul_lo(ptc_pkg::asr(st_q[1].y, 12), t3);
    st_d[3]   = st_q[2];
    st_d[3].w = st_q[2].x + ptc_pkg::asr(st_q[2].y, 14);
    st_d[4]      = st_q[3];
    st_d[4].temp = ptc_pkg::asr((st_q[3].w << 2) + st_q[3].w + ptc_pkg::TRound, 8);
    st_d[4].x    = ptc_pkg::asr(st_q[3].w, 1) - ptc_pkg::POffset;
    st_d[4].y    = ptc_pkg::asr(ptc_pkg::asr(st_q[3].w, 1) - ptc_pkg::POffset, 2);
    // pressure
    st_d[5]   = st_q[4];
    st_d[5].y = ptc_pkg::mul_lo(st_q[4].y, st_q[4].y);
    st_d[5].z = ptc_pkg::mul_lo(st_q[4].x, p5);
    st_d[5].w = ptc_pkg::mul_lo(p2, st_q[4].x);
    st_d[6]   = st_q[5];
    st_d[6].x = ptc_pkg::mul_lo(ptc_pkg::asr(st_q[5].y, 11), p6);
    st_d[6].y = ptc_pkg::mul_lo(p3, ptc_pkg::asr(st_q[5].y, 13));
    st_d[7]   = st_q[6];
    st_d[7].x = ptc_pkg::asr(st_q[6].x + (st_q[6].z << 1), 2) + (p4 << 16);
    st_d[7].y = ptc_pkg::asr(ptc_pkg::asr(st_q[6].y, 3) + ptc_pkg::asr(st_q[6].w, 1), 18);
    st_d[8]   = st_q[7];
    st_d[8].y = ptc_pkg::mul_lo(ptc_pkg::POne + st_q[7].y, p1);
    st_d[9]   = st_q[8];
    st_d[9].y = ptc_pkg::asr(st_q[8].y, 15);
    st_d[9].z = ptc_pkg::mul_lo((ptc_pkg::PRawFull - {12'd0, st_q[8].adc_p})
                                - ptc_pkg::asr(st_q[8].x, 12), ptc_pkg::PScale);
    // after the divider
    pres = div_side_out.dbl ? {div_q[30:0], 1'b0} : div_q;
    pt_d[0]      = '0;
    pt_d[0].ok   = div_side_out.ok;
    pt_d[0].zero = div_side_out.zero;
    pt_d[0].temp = div_side_out.temp;
    pt_d[0].z    = pres;
    pt_d[0].x    = ptc_pkg::mul_lo(pres >> 3, pres >> 3);
    pt_d[0].y    = ptc_pkg::mul_lo(pres >> 2, p8);
    pt_d[1]   = pt_q[0];
    pt_d[1].x = ptc_pkg::mul_lo(p9, pt_q[0].x >> 13);
    pt_d[1].y = ptc_pkg::asr(pt_q[0].y, 13);
    pt_d[2]      = pt_q[1];
    pt_d[2].temp = pt_q[1].ok ? pt_q[1].temp : '0;
    pt_d[2].z    = (pt_q[1].ok && !pt_q[1].zero)
                 ? pt_q[1].z + ptc_pkg::asr(ptc_pkg::asr(pt_q[1].x, 12) + pt_q[1].y + p7, 4)
                 : '0;
  end

  assign div_in_v          = sv_q[NPre];
  assign div_dvd           = (st_q[NPre].z < ptc_pkg::PHalfRange) ? {st_q[NPre].z[30:0], 1'b0}
                                                                  : st_q[NPre].z;
  assign div_side_in.ok    = st_q[NPre].ok;
  assign div_side_in.zero  = (st_q[NPre].y == '0);
  assign div_side_in.dbl   = !(st_q[NPre].z < ptc_pkg::PHalfRange);
  assign div_side_in.temp  = st_q[NPre].temp;

  ptc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (div_in_v),
    .dividend_i (div_dvd),
    .divisor_i  (st_q[NPre].y),
    .side_i     (div_side_in),
    .valid_o    (div_out_v),
    .quotient_o (div_q),
    .side_o     (div_side_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NPre; k++) begin
        sv_q[k] <= 1'b0;
      end
      for (int k = 0; k < NPost; k++) begin
        pv_q[k] <= 1'b0;
      end
    end else if (en) begin
      sv_q[1] <= q_pop_o;
      for (int k = 2; k <= NPre; k++) begin
        sv_q[k] <= sv_q[k-1];
      end
      pv_q[0] <= div_out_v;
      for (int k = 1; k < NPost; k++) begin
        pv_q[k] <= pv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k <= NPre; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 0; k < NPost; k++) begin
        pt_q[k] <= pt_d[k];
      end
    end
  end

  assign out_valid_o         = pv_q[NPost-1];
  assign temperature_centi_o = pt_q[NPost-1].temp;
  assign pressure_pa_o       = pt_q[NPost-1].z;
  assign device_ok_o         = pt_q[NPost-1].ok;

`ifndef ASSERT_OFF
  a_bad_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !device_ok_o |-> temperature_centi_o == '0 && pressure_pa_o == '0)
    else $error("bad identity item with nonzero result");
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_i.p1 == '0 |-> pressure_pa_o == '0)
    else $error("zero divisor item with nonzero pressure");
`endif

endmodule

/* rtl/core/pressure_temperature_compensation.sv */
// top level: calibration registers, front end, queue and datapath
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | chip_id_i and six raw bytes
//  out     | output    | out_valid_o/out_stall_i | temperature, pressure, ok flag
//  cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
//  one item per cycle sustained while the output is not stalled
//  the path runs through the 32-stage divider plus 12 multiply and output stages
//  reset clears calibration registers, queue pointers and pipeline valids
//  an output stall with a result waiting freezes the datapath; the queue absorbs up to its depth
module pressure_temperature_compensation #(
  parameter int QDepth = ptc_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  chip_id_i,
  input  logic [7:0]                  press_msb_i,
  input  logic [7:0]                  press_lsb_i,
  input  logic [7:0]                  press_xlsb_i,
  input  logic [7:0]                  temp_msb_i,
  input  logic [7:0]                  temp_lsb_i,
  input  logic [7:0]                  temp_xlsb_i,
  input  logic                        cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          temperature_centi_o,
  output logic [31:0]                 pressure_pa_o,
  output logic                        device_ok_o
);

  ptc_pkg::cfg_t  cfg_q;
  ptc_pkg::meas_t front_meas, q_meas;
  logic           push, full, pop, empty;
  logic [31:0]    temp_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (ptc_pkg::reg_idx_e'(cfg_idx_i))
        ptc_pkg::RegT1:  cfg_q.t1  <= cfg_data_i[15:0];
        ptc_pkg::RegT2:  cfg_q.t2  <= cfg_data_i[15:0];
        ptc_pkg::RegT3:  cfg_q.t3  <= cfg_data_i[15:0];
        ptc_pkg::RegP1:  cfg_q.p1  <= cfg_data_i[15:0];
        ptc_pkg::RegP23: cfg_q.p23 <= cfg_data_i;
        ptc_pkg::RegP45: cfg_q.p45 <= cfg_data_i;
        ptc_pkg::RegP67: cfg_q.p67 <= cfg_data_i;
        ptc_pkg::RegP89: cfg_q.p89 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .chip_id_i    (chip_id_i),
    .press_msb_i  (press_msb_i),
    .press_lsb_i  (press_lsb_i),
    .press_xlsb_i (press_xlsb_i),
    .temp_msb_i   (temp_msb_i),
    .temp_lsb_i   (temp_lsb_i),
    .temp_xlsb_i  (temp_xlsb_i),
    .full_i       (full),
    .push_o       (push),
    .meas_o       (front_meas)
  );

  ptc_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_meas),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_meas)
  );

  ptc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .q_empty_i           (empty),
    .q_data_i            (q_meas),
    .q_pop_o             (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temp_raw),
    .pressure_pa_o       (pressure_pa_o),
    .device_ok_o         (device_ok_o)
  );

  assign temperature_centi_o = $signed(temp_raw);

endmodule

/* sim/pressure_temperature_compensation_test.sv */
// testbench for the pressure and temperature compensation block
`timescale 1ns / 1ps

class comp_scoreboard;
  logic [31:0] exp_temp[$];
  logic [31:0] exp_pres[$];
  logic        exp_ok[$];
  int          errors;
  int          checked;

  function void note_item(logic [31:0] t, logic [31:0] p, logic ok);
    exp_temp.push_back(t);
    exp_pres.push_back(p);
    exp_ok.push_back(ok);
  endfunction

  function void check_result(logic [31:0] t, logic [31:0] p, logic ok);
    logic [31:0] et, ep;
    logic        eo;
    if (exp_temp.size() == 0) begin
      $display("%0t unexpected result temp %h pres %h ok %b", $time, t, p, ok);
      errors++;
      return;
    end
    et = exp_temp.pop_front();
    ep = exp_pres.pop_front();
    eo = exp_ok.pop_front();
    checked++;
    if (t !== et) begin
      $display("%0t temperature mismatch expected %h actual %h", $time, et, t);
      errors++;
    end
    if (p !== ep) begin
      $display("%0t pressure mismatch expected %h actual %h", $time, ep, p);
      errors++;
    end
    if (ok !== eo) begin
      $display("%0t ok flag mismatch expected %b actual %b", $time, eo, ok);
      errors++;
    end
  endfunction

  function int pending();
    return exp_temp.size();
  endfunction
endclass

module pressure_temperature_compensation_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] chip_id = '0, p_msb = '0, p_lsb = '0, p_xlsb = '0;
  logic [7:0] t_msb = '0, t_lsb = '0, t_xlsb = '0;
  logic cfg_we = 1'b0;
  logic [ptc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] temp_out;
  logic [31:0] pres_out;
  logic ok_out;

  logic [31:0] trim[8];
  comp_scoreboard sb;
  int stall_mode;
  int n_good, n_bad;

  always #2 clk = ~clk;

  pressure_temperature_compensation dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .chip_id_i(chip_id), .press_msb_i(p_msb), .press_lsb_i(p_lsb),
    .press_xlsb_i(p_xlsb), .temp_msb_i(t_msb), .temp_lsb_i(t_lsb),
    .temp_xlsb_i(t_xlsb), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .temperature_centi_o(temp_out), .pressure_pa_o(pres_out), .device_ok_o(ok_out)
  );

  function automatic logic [31:0] sra(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic compensate(input logic [7:0] b[7], output logic [31:0] temp,
                            output logic [31:0] pres, output logic ok);
    logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, c, d, sq, fine, q, r;
    if (b[0] != ptc_pkg::ChipId) begin
      temp = '0; pres = '0; ok = 1'b0;
      return;
    end
    ok = 1'b1;
    adc_p = {12'd0, b[1], b[2], b[3][7:4]};
    adc_t = {12'd0, b[4], b[5], b[6][7:4]};
    t1 = {16'd0, trim[ptc_pkg::RegT1][15:0]};
    t2 = ext16(trim[ptc_pkg::RegT2][15:0]);
    t3 = ext16(trim[ptc_pkg::RegT3][15:0]);
    p1 = {16'd0, trim[ptc_pkg::RegP1][15:0]};
    p2 = ext16(trim[ptc_pkg::RegP23][15:0]);  p3 = ext16(trim[ptc_pkg::RegP23][31:16]);
    p4 = ext16(trim[ptc_pkg::RegP45][15:0]);  p5 = ext16(trim[ptc_pkg::RegP45][31:16]);
    p6 = ext16(trim[ptc_pkg::RegP67][15:0]);  p7 = ext16(trim[ptc_pkg::RegP67][31:16]);
    p8 = ext16(trim[ptc_pkg::RegP89][15:0]);  p9 = ext16(trim[ptc_pkg::RegP89][31:16]);
    a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    c = sra(sra(d * d, 12) * t3, 14);
    fine = a + c;
    temp = sra(fine * 32'd5 + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    sq = sra(a, 2) * sra(a, 2);
    c = sra(sq, 11) * p6;
    c = c + ((a * p5) << 1);
    c = sra(c, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      pres = '0;
    end else begin
      q = ((32'd1048576 - adc_p) - sra(c, 12)) * 32'd3125;
      if (q < 32'h8000_0000) q = (q << 1) / a;
      else q = (q / a) * 32'd2;
      r = (q >> 3) * (q >> 3);
      d = sra(p9 * (r >> 13), 12);
      c = sra((q >> 2) * p8, 13);
      pres = q + sra(d + c + p7, 4);
    end
  endtask

  task automatic write_trim(input ptc_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    trim[idx] = (idx <= ptc_pkg::RegP1) ? {16'd0, val[15:0]} : val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] b[7]);
    logic [31:0] t, p;
    logic ok;
    chip_id <= b[0]; p_msb <= b[1]; p_lsb <= b[2]; p_xlsb <= b[3];
    t_msb <= b[4]; t_lsb <= b[5]; t_xlsb <= b[6];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    compensate(b, t, p, ok);
    sb.note_item(t, p, ok);
    if (ok) n_good++; else n_bad++;
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_trims(input int style);
    int i;
    for (i = 0; i < 8; i++) begin
      case (style)
        0: write_trim(ptc_pkg::reg_idx_e'(i), 32'h0000_0000);
        1: write_trim(ptc_pkg::reg_idx_e'(i), 32'hFFFF_FFFF);
        2: write_trim(ptc_pkg::reg_idx_e'(i), 32'h8000_8000);
        3: write_trim(ptc_pkg::reg_idx_e'(i), 32'h7FFF_7FFF);
        default: write_trim(ptc_pkg::reg_idx_e'(i), $urandom());
      endcase
    end
  endtask

  task automatic typical_trims();
    write_trim(ptc_pkg::RegT1, 32'd27504);
    write_trim(ptc_pkg::RegT2, 32'd26435);
    write_trim(ptc_pkg::RegT3, 32'hFFFF_FC18);
    write_trim(ptc_pkg::RegP1, 32'd36477);
    write_trim(ptc_pkg::RegP23, {16'd3024, 16'hD4C6});
    write_trim(ptc_pkg::RegP45, {16'h0000 - 16'd140 + 16'd0, 16'd2855} + 32'h0);
    write_trim(ptc_pkg::RegP67, {16'd15500, 16'hFFF9});
    write_trim(ptc_pkg::RegP89, {16'd6000, 16'hC5F0});
  endtask

  task automatic random_item(output logic [7:0] b[7]);
    int i;
    for (i = 1; i < 7; i++) b[i] = $urandom();
    b[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : ptc_pkg::ChipId;
  endtask

  initial begin
    int k;
    forever begin
      @(posedge clk);
      k = $urandom_range(0, 99);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= (k < 30);
        default: out_stall <= (k < 80);
      endcase
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(temp_out, pres_out, ok_out);
    end
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] b[7];
    int ph, n, i;
    sb = new();
    stall_mode = 0;
    for (i = 0; i < 8; i++) trim[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset trims, then typical trims with edge inputs and bad identity bytes, then a zero P1
    b = '{ptc_pkg::ChipId, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_item(b);
    drain();
    typical_trims();
    b = '{ptc_pkg::ChipId, 8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00}; send_item(b);
    b = '{ptc_pkg::ChipId, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; send_item(b);
    b = '{ptc_pkg::ChipId, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_item(b);
    b = '{ptc_pkg::ChipId, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h0F}; send_item(b);
    b = '{ptc_pkg::ChipId, 8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 8'hF0}; send_item(b);
    b = '{8'h00, 8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00}; send_item(b);
    b = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_item(b);
    b = '{8'h59, 8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00}; send_item(b);
    b = '{8'hA7, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC}; send_item(b);
    drain();
    write_trim(ptc_pkg::RegP1, 32'h0);
    b = '{ptc_pkg::ChipId, 8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00}; send_item(b);
    drain();

    // random phases across trim settings and stall patterns
    for (ph = 0; ph < 10; ph++) begin
      stall_mode = ph % 3;
      if (ph == 0) typical_trims();
      else random_trims(ph < 5 ? ph - 1 : 4);
      if (ph >= 5 && ph % 2 == 1) write_trim(ptc_pkg::RegP1, $urandom_range(1, 65535));
      for (n = 0; n < 200; n++) begin
        random_item(b);
        send_item(b);
        if (n % 50 > 30) idle_gap();
      end
      drain();
    end
    $display("covered %0d good-id and %0d bad-id items, %0d results checked",
             n_good, n_bad, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
